@@ hdl/gpdz_pkg.sv @@
`default_nettype none
package gpdz_pkg;

   localparam int FRAC_BITS = 15;
   localparam logic [FRAC_BITS-1:0] FULL_SCALE = {FRAC_BITS{1'b1}};

   // pipeline depth of one stick lane, front clamp to output register
   localparam int LANE_LAT = 52;

   localparam logic REG_DRIVE_DZ  = 1'b0;
   localparam logic REG_CAMERA_DZ = 1'b1;

   localparam logic [FRAC_BITS-1:0] DRIVE_DZ_RESET  = 15'd7849;
   localparam logic [FRAC_BITS-1:0] CAMERA_DZ_RESET = 15'd7864;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
   } lane_out_type;

   typedef struct packed {
      logic               conn;
      logic signed [15:0] zoom;
   } side_type;

endpackage
`default_nettype wire

@@ hdl/gamepad_radial_dead_zone_axes.sv @@
`default_nettype none
// Channel   Dir  Handshake              Payload
// req_      in   req_valid/req_ready    connected, sticks, triggers
// rsp_      out  rsp_valid/rsp_ready    throttle, depth, pan_x, pan_y, zoom
// csr_      in   csr_wr_en              csr_index, csr_wdata
//
// One sample per cycle sustained while not stalled. Each of the two stick
// lanes has 52 stages, a 16-stage square root and two 15-stage divider
// levels in series among them, followed by the merge register. The whole
// pipeline advances together and holds while a finished beat waits on
// rsp_ready. Reset clears valid state and loads dead-zone register defaults.
module gamepad_radial_dead_zone_axes (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_connected,
   input  wire logic signed [15:0] req_left_x,
   input  wire logic signed [15:0] req_left_y,
   input  wire logic signed [15:0] req_right_x,
   input  wire logic signed [15:0] req_right_y,
   input  wire logic [14:0]        req_left_trigger,
   input  wire logic [14:0]        req_right_trigger,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_throttle,
   output logic signed [15:0]      rsp_depth,
   output logic signed [15:0]      rsp_pan_x,
   output logic signed [15:0]      rsp_pan_y,
   output logic signed [15:0]      rsp_zoom,
   input  wire logic               csr_wr_en,
   input  wire logic               csr_index,
   input  wire logic [14:0]        csr_wdata
);

   localparam int LAT = gpdz_pkg::LANE_LAT;

   logic [14:0] drive_dz_ff, camera_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_dz_ff  <= gpdz_pkg::DRIVE_DZ_RESET;
         camera_dz_ff <= gpdz_pkg::CAMERA_DZ_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            gpdz_pkg::REG_DRIVE_DZ:  drive_dz_ff  <= csr_wdata;
            gpdz_pkg::REG_CAMERA_DZ: camera_dz_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic rsp_valid_ff;
   logic en;

   assign en        = !rsp_valid_ff || rsp_ready;
   // no beat is taken while reset holds the valid line clear
   assign req_ready = en && !reset;

   gpdz_pkg::lane_out_type left_res, right_res;

   gpdz_lane u_lane_left (
      .clock  (clock),
      .en     (en),
      .in_x   (req_left_x),
      .in_y   (req_left_y),
      .dz     (drive_dz_ff),
      .result (left_res)
   );

   gpdz_lane u_lane_right (
      .clock  (clock),
      .en     (en),
      .in_x   (req_right_x),
      .in_y   (req_right_y),
      .dz     (camera_dz_ff),
      .result (right_res)
   );

   // valid and sideband delay lines matching lane depth
   logic                vld_ff [LAT];
   gpdz_pkg::side_type  dly_ff [LAT];
   gpdz_pkg::side_type  side_in;

   always_comb begin
      side_in.conn = req_connected;
      side_in.zoom = $signed({1'b0, req_right_trigger}) - $signed({1'b0, req_left_trigger});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dly_ff[0] <= side_in;
         for (int k = 1; k < LAT; k++) dly_ff[k] <= dly_ff[k-1];
      end
   end

   // merge stage
   logic signed [15:0] throttle_ff, depth_ff, pan_x_ff, pan_y_ff, zoom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (dly_ff[LAT-1].conn) begin
            throttle_ff <= left_res.x;
            depth_ff    <= -left_res.y;
            pan_x_ff    <= right_res.x;
            pan_y_ff    <= right_res.y;
            zoom_ff     <= dly_ff[LAT-1].zoom;
         end else begin
            throttle_ff <= '0;
            depth_ff    <= '0;
            pan_x_ff    <= '0;
            pan_y_ff    <= '0;
            zoom_ff     <= '0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_throttle = throttle_ff;
   assign rsp_depth    = depth_ff;
   assign rsp_pan_x    = pan_x_ff;
   assign rsp_pan_y    = pan_y_ff;
   assign rsp_zoom     = zoom_ff;

   a_hold_tail : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff[LAT-1]))
      else $error("pipeline tail moved during stall");

   a_axis_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (throttle_ff != 16'sh8000) && (depth_ff != 16'sh8000)
                       && (pan_x_ff != 16'sh8000) && (pan_y_ff != 16'sh8000))
      else $error("axis result outside full scale");

   a_zoom_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> zoom_ff != 16'sh8000)
      else $error("zoom outside full scale");

endmodule
`default_nettype wire

@@ hdl/gpdz_isqrt.sv @@
`default_nettype none
// Digit-by-digit integer square root, one root bit per stage.
module gpdz_isqrt #(
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [31:0]       rad,
   input  wire logic [SIDE_W-1:0] side_in,
   output logic      [15:0]       root,
   output logic      [SIDE_W-1:0] side_out
);

   localparam int RW = 16;
   localparam int NW = 2 * RW;

   logic [RW+1:0]     rem_ff  [RW];
   logic [RW-1:0]     root_ff [RW];
   logic [NW-1:0]     rad_ff  [RW];
   logic [SIDE_W-1:0] side_ff [RW];

   logic [RW+1:0]     rem_in  [RW];
   logic [RW-1:0]     root_in [RW];
   logic [NW-1:0]     rad_in  [RW];
   logic [SIDE_W-1:0] side_in_s [RW];

   always_comb begin
      logic [RW+1:0]     p_rem;
      logic [RW-1:0]     p_root;
      logic [NW-1:0]     p_rad;
      logic [SIDE_W-1:0] p_side;
      logic [RW+3:0]     cur;
      logic [RW+3:0]     trial;
      for (int k = 0; k < RW; k++) begin
         if (k == 0) begin
            p_rem  = '0;
            p_root = '0;
            p_rad  = rad;
            p_side = side_in;
         end else begin
            p_rem  = rem_ff[k-1];
            p_root = root_ff[k-1];
            p_rad  = rad_ff[k-1];
            p_side = side_ff[k-1];
         end
         cur   = {p_rem, p_rad[NW-1 -: 2]};
         trial = {2'b00, p_root, 2'b01};
         if (cur >= trial) begin
            rem_in[k]  = (RW+2)'(cur - trial);
            root_in[k] = {p_root[RW-2:0], 1'b1};
         end else begin
            rem_in[k]  = cur[RW+1:0];
            root_in[k] = {p_root[RW-2:0], 1'b0};
         end
         rad_in[k]    = p_rad << 2;
         side_in_s[k] = p_side;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < RW; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
            side_ff[k] <= side_in_s[k];
         end
      end
   end

   assign root     = root_ff[RW-1];
   assign side_out = side_ff[RW-1];

endmodule
`default_nettype wire

@@ hdl/gpdz_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per stage. Caller guarantees
// num < den * 2^QW so the quotient fits in QW bits.
module gpdz_div #(
   parameter int NW     = 30,
   parameter int DW     = 15,
   parameter int QW     = 15,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [NW-1:0]     num,
   input  wire logic [DW-1:0]     den,
   input  wire logic [SIDE_W-1:0] side_in,
   output logic      [QW-1:0]     quo,
   output logic      [SIDE_W-1:0] side_out
);

   logic [DW-1:0]     rem_ff  [QW];
   logic [QW-1:0]     lo_ff   [QW];
   logic [QW-1:0]     quo_ff  [QW];
   logic [DW-1:0]     den_ff  [QW];
   logic [SIDE_W-1:0] side_ff [QW];

   logic [DW-1:0]     rem_in  [QW];
   logic [QW-1:0]     lo_in   [QW];
   logic [QW-1:0]     quo_in  [QW];
   logic [DW-1:0]     den_in  [QW];
   logic [SIDE_W-1:0] side_nx [QW];

   always_comb begin
      logic [DW-1:0]     p_rem;
      logic [QW-1:0]     p_lo;
      logic [QW-1:0]     p_quo;
      logic [DW-1:0]     p_den;
      logic [SIDE_W-1:0] p_side;
      logic [DW:0]       cur;
      for (int k = 0; k < QW; k++) begin
         if (k == 0) begin
            p_rem  = DW'(num >> QW);
            p_lo   = num[QW-1:0];
            p_quo  = '0;
            p_den  = den;
            p_side = side_in;
         end else begin
            p_rem  = rem_ff[k-1];
            p_lo   = lo_ff[k-1];
            p_quo  = quo_ff[k-1];
            p_den  = den_ff[k-1];
            p_side = side_ff[k-1];
         end
         cur = {p_rem, p_lo[QW-1]};
         if (cur >= {1'b0, p_den}) begin
            rem_in[k] = DW'(cur - {1'b0, p_den});
            quo_in[k] = {p_quo[QW-2:0], 1'b1};
         end else begin
            rem_in[k] = cur[DW-1:0];
            quo_in[k] = {p_quo[QW-2:0], 1'b0};
         end
         lo_in[k]   = p_lo << 1;
         den_in[k]  = p_den;
         side_nx[k] = p_side;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QW; k++) begin
            rem_ff[k]  <= rem_in[k];
            lo_ff[k]   <= lo_in[k];
            quo_ff[k]  <= quo_in[k];
            den_ff[k]  <= den_in[k];
            side_ff[k] <= side_nx[k];
         end
      end
   end

   assign quo      = quo_ff[QW-1];
   assign side_out = side_ff[QW-1];

endmodule
`default_nettype wire

@@ hdl/gpdz_lane.sv @@
`default_nettype none
// One stick: clamp, magnitude, dead-zone rescale, per-axis scaling.
module gpdz_lane (
   input  wire logic                clock,
   input  wire logic                en,
   input  wire logic signed [15:0]  in_x,
   input  wire logic signed [15:0]  in_y,
   input  wire logic [14:0]         dz,
   output gpdz_pkg::lane_out_type   result
);

   localparam logic [14:0] FS = gpdz_pkg::FULL_SCALE;

   // stage 1: clamp and magnitude per axis
   logic [14:0] ax1_ff, ay1_ff;
   logic        sx1_ff, sy1_ff;
   logic [14:0] ax1_in, ay1_in;

   always_comb begin
      logic signed [15:0] cx, cy;
      cx = (in_x == 16'sh8000) ? -16'sd32767 : in_x;
      cy = (in_y == 16'sh8000) ? -16'sd32767 : in_y;
      ax1_in = cx[15] ? 15'(-cx) : cx[14:0];
      ay1_in = cy[15] ? 15'(-cy) : cy[14:0];
   end

   // stage 2: squares, stage 3: sum
   logic [29:0] xx2_ff, yy2_ff;
   logic [14:0] ax2_ff, ay2_ff;
   logic        sx2_ff, sy2_ff;
   logic [31:0] sum3_ff;
   logic [31:0] side3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ax1_ff   <= ax1_in;
         ay1_ff   <= ay1_in;
         sx1_ff   <= in_x[15];
         sy1_ff   <= in_y[15];
         xx2_ff   <= ax1_ff * ax1_ff;
         yy2_ff   <= ay1_ff * ay1_ff;
         ax2_ff   <= ax1_ff;
         ay2_ff   <= ay1_ff;
         sx2_ff   <= sx1_ff;
         sy2_ff   <= sy1_ff;
         sum3_ff  <= 32'(xx2_ff) + 32'(yy2_ff);
         side3_ff <= {ax2_ff, ay2_ff, sx2_ff, sy2_ff};
      end
   end

   logic [15:0] m_s;
   logic [31:0] side_sq;

   gpdz_isqrt #(.SIDE_W(32)) u_isqrt (
      .clock    (clock),
      .en       (en),
      .rad      (sum3_ff),
      .side_in  (side3_ff),
      .root     (m_s),
      .side_out (side_sq)
   );

   // stage 4: dead-zone test and rescale numerator
   logic [29:0] num4_ff;
   logic [14:0] den4_ff;
   logic [48:0] side4_ff;
   logic        zero4_in;
   logic [14:0] mb4_in;

   always_comb begin
      zero4_in = (dz >= FS) || (m_s == '0) || (m_s <= {1'b0, dz});
      mb4_in   = (m_s > {1'b0, FS}) ? FS : m_s[14:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num4_ff  <= 15'(mb4_in - dz) * FS;
         den4_ff  <= FS - dz;
         side4_ff <= {side_sq, zero4_in, m_s};
      end
   end

   logic [14:0] s_q;
   logic [48:0] side_s;

   gpdz_div #(.NW(30), .DW(15), .QW(15), .SIDE_W(49)) u_div_s (
      .clock    (clock),
      .en       (en),
      .num      (num4_ff),
      .den      (den4_ff),
      .side_in  (side4_ff),
      .quo      (s_q),
      .side_out (side_s)
   );

   // stage 5: axis times scaled magnitude
   logic [29:0] px5_ff, py5_ff;
   logic [15:0] m5_ff;
   logic [1:0]  sidex5_ff;
   logic        sidey5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         px5_ff    <= side_s[48:34] * s_q;
         py5_ff    <= side_s[33:19] * s_q;
         m5_ff     <= side_s[15:0];
         sidex5_ff <= {side_s[18], side_s[16]};
         sidey5_ff <= side_s[17];
      end
   end

   logic [14:0] qx, qy;
   logic [1:0]  side_x;
   logic        side_y;

   gpdz_div #(.NW(30), .DW(16), .QW(15), .SIDE_W(2)) u_div_x (
      .clock    (clock),
      .en       (en),
      .num      (px5_ff),
      .den      (m5_ff),
      .side_in  (sidex5_ff),
      .quo      (qx),
      .side_out (side_x)
   );

   gpdz_div #(.NW(30), .DW(16), .QW(15), .SIDE_W(1)) u_div_y (
      .clock    (clock),
      .en       (en),
      .num      (py5_ff),
      .den      (m5_ff),
      .side_in  (sidey5_ff),
      .quo      (qy),
      .side_out (side_y)
   );

   // stage 6: sign restore, zero inside the dead zone
   gpdz_pkg::lane_out_type result_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (side_x[0]) begin
            result_ff.x <= '0;
            result_ff.y <= '0;
         end else begin
            result_ff.x <= side_x[1] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
            result_ff.y <= side_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
         end
      end
   end

   assign result = result_ff;

endmodule
`default_nettype wire
